// ===== sv/neighbor_cache_table_unit_macros.svh =====
// assertion macros shared by the neighbor cache table rtl
// no dependencies; included by the controller and the datapath
`ifndef NEIGHBOR_CACHE_TABLE_UNIT_MACROS_SVH
`define NEIGHBOR_CACHE_TABLE_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define NCT_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define NCT_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/nct_pkg.sv =====
// shared types and constants of the neighbor cache table
// no dependencies
`default_nettype none

package nct_pkg;

  typedef enum logic [1:0] {
    FUNC_UPDATE = 2'd0,
    FUNC_LOOKUP = 2'd1,
    FUNC_AGE    = 2'd2,
    FUNC_NONE   = 2'd3
  } func_e;

  // configuration register indexes
  localparam logic REG_REACHABLE_LIMIT = 1'b0;
  localparam logic REG_STALE_LIMIT     = 1'b1;

  localparam logic [31:0] REACHABLE_LIMIT_RST = 32'd30000;
  localparam logic [31:0] STALE_LIMIT_RST     = 32'd120000;

  localparam int unsigned KEY_W  = 64;
  localparam int unsigned MAC_W  = 48;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned SLOT_W = 5;
  localparam int unsigned RM_W   = 6;

  localparam logic [RM_W-1:0] RM_MAX = '1;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan_step;
    logic commit;
    logic emit;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last_eval;
    logic is_update;
  } dp_status_t;

  // one result item, hit in the lowest bit
  typedef struct packed {
    logic [RM_W-1:0]   removed_count;
    logic              evicted;
    logic [SLOT_W-1:0] slot;
    logic [MAC_W-1:0]  mac_out;
    logic              hit;
  } result_t;

endpackage

`default_nettype wire

// ===== sv/nct_ctrl.sv =====
// request sequencer of the neighbor cache table
// uses nct_pkg and the assertion macros header
`default_nettype none

`include "neighbor_cache_table_unit_macros.svh"

module nct_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic [1:0]             in_func_i,
  output logic                   in_ready_o,
  input  logic                   out_free_i,
  input  nct_pkg::dp_status_t    status_i,
  output nct_pkg::ctrl_cmd_t     cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (nct_pkg::func_e'(in_func_i) == nct_pkg::FUNC_NONE) begin
            state_d = ST_FINISH;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (status_i.last_eval) begin
          state_d = status_i.is_update ? ST_COMMIT : ST_FINISH;
        end
      end
      ST_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free_i) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `NCT_ASSERT_IMP(a_emit_free, clk_i, rst_ni, cmd_o.emit, out_free_i, "emit into a full output stage")
  `NCT_ASSERT_IMP(a_commit_after_scan, clk_i, rst_ni, cmd_o.commit, $past(status_i.last_eval && status_i.is_update), "commit without a finished update scan")
  `NCT_ASSERT_NXT(a_one_at_a_time, clk_i, rst_ni, cmd_o.load, !in_ready_o, "request taken while one is in flight")

endmodule

`default_nettype wire

// ===== sv/nct_dp.sv =====
// entry storage, scan pipeline and result logic of the neighbor cache table
// uses nct_pkg and the assertion macros header
`default_nettype none

`include "neighbor_cache_table_unit_macros.svh"

module nct_dp #(
  parameter int unsigned ENTRIES = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  nct_pkg::ctrl_cmd_t                cmd_i,
  input  logic [1:0]                        in_func_i,
  input  logic [nct_pkg::KEY_W-1:0]         in_addr_high_i,
  input  logic [nct_pkg::KEY_W-1:0]         in_addr_low_i,
  input  logic [nct_pkg::MAC_W-1:0]         in_new_mac_i,
  input  logic [nct_pkg::TIME_W-1:0]        in_now_i,
  input  logic [nct_pkg::TIME_W-1:0]        reach_lim_i,
  input  logic [nct_pkg::TIME_W-1:0]        stale_lim_i,
  output nct_pkg::dp_status_t               status_o,
  output nct_pkg::result_t                  result_o
);

  localparam int unsigned IdxW = $clog2(ENTRIES);
  localparam int unsigned CntW = $clog2(ENTRIES + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(ENTRIES - 1);

  // request payload
  nct_pkg::func_e                func_q;
  logic [nct_pkg::KEY_W-1:0]     key_h_q, key_l_q;
  logic [nct_pkg::MAC_W-1:0]     mac_q;
  logic [nct_pkg::TIME_W-1:0]    now_q;

  // table storage
  logic [nct_pkg::KEY_W-1:0]     mem_kh    [ENTRIES];
  logic [nct_pkg::KEY_W-1:0]     mem_kl    [ENTRIES];
  logic [nct_pkg::MAC_W-1:0]     mem_mac   [ENTRIES];
  logic [nct_pkg::TIME_W-1:0]    mem_seen  [ENTRIES];
  logic                          mem_stale [ENTRIES];
  logic [ENTRIES-1:0]            valid_q;
  logic [IdxW-1:0]               evict_ptr_q;

  // read data
  logic [nct_pkg::KEY_W-1:0]     rd_kh_q, rd_kl_q;
  logic [nct_pkg::MAC_W-1:0]     rd_mac_q;
  logic [nct_pkg::TIME_W-1:0]    rd_seen_q;
  logic                          rd_stale_q;

  // scan control
  logic [CntW-1:0]               cnt_q;
  logic                          ev_vld_q;
  logic [IdxW-1:0]               ev_idx_q;
  logic                          issue;

  // scan accumulators
  logic                          match_q, free_q, evicted_q;
  logic [IdxW-1:0]               match_idx_q, free_idx_q, wslot_q;
  logic [nct_pkg::MAC_W-1:0]     found_mac_q;
  logic [nct_pkg::RM_W-1:0]      rm_q;

  logic                          ev_valid, key_hit, is_age;
  logic [nct_pkg::TIME_W-1:0]    age;
  logic                          stale_new, age_kill;
  logic [IdxW-1:0]               widx;
  logic                          do_evict;
  logic                          stale_we, stale_wd;
  logic [IdxW-1:0]               stale_wa;

  assign issue    = cmd_i.scan_step && (cnt_q < CntW'(ENTRIES));
  assign ev_valid = valid_q[ev_idx_q];
  assign key_hit  = ev_valid && (rd_kh_q == key_h_q) && (rd_kl_q == key_l_q);
  assign is_age   = (func_q == nct_pkg::FUNC_AGE);

  assign age       = now_q - rd_seen_q;
  assign stale_new = rd_stale_q || (age > reach_lim_i);
  assign age_kill  = ev_vld_q && is_age && ev_valid && stale_new && (age > stale_lim_i);

  assign do_evict = !match_q && !free_q;
  assign widx     = match_q ? match_idx_q : (free_q ? free_idx_q : evict_ptr_q);

  // stale flag is written by commit or by an age evaluation, never both
  always_comb begin
    stale_we = 1'b0;
    stale_wa = widx;
    stale_wd = 1'b0;
    if (cmd_i.commit) begin
      stale_we = 1'b1;
    end else if (ev_vld_q && is_age && ev_valid) begin
      stale_we = 1'b1;
      stale_wa = ev_idx_q;
      stale_wd = stale_new;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q  <= nct_pkg::func_e'(in_func_i);
      key_h_q <= in_addr_high_i;
      key_l_q <= in_addr_low_i;
      mac_q   <= in_new_mac_i;
      now_q   <= in_now_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      mem_kh[widx]   <= key_h_q;
      mem_kl[widx]   <= key_l_q;
      mem_mac[widx]  <= mac_q;
      mem_seen[widx] <= now_q;
    end
    if (stale_we) begin
      mem_stale[stale_wa] <= stale_wd;
    end
    if (issue) begin
      rd_kh_q    <= mem_kh[cnt_q[IdxW-1:0]];
      rd_kl_q    <= mem_kl[cnt_q[IdxW-1:0]];
      rd_mac_q   <= mem_mac[cnt_q[IdxW-1:0]];
      rd_seen_q  <= mem_seen[cnt_q[IdxW-1:0]];
      rd_stale_q <= mem_stale[cnt_q[IdxW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      evict_ptr_q <= '0;
    end else if (cmd_i.commit) begin
      valid_q[widx] <= 1'b1;
      if (do_evict) begin
        evict_ptr_q <= (evict_ptr_q == LastIdx) ? '0 : evict_ptr_q + IdxW'(1);
      end
    end else if (age_kill) begin
      valid_q[ev_idx_q] <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      ev_vld_q  <= 1'b0;
      ev_idx_q  <= '0;
      match_q   <= 1'b0;
      free_q    <= 1'b0;
      evicted_q <= 1'b0;
      rm_q      <= '0;
    end else if (cmd_i.load) begin
      cnt_q     <= '0;
      ev_vld_q  <= 1'b0;
      match_q   <= 1'b0;
      free_q    <= 1'b0;
      evicted_q <= 1'b0;
      rm_q      <= '0;
    end else begin
      ev_vld_q <= issue;
      if (issue) begin
        ev_idx_q <= cnt_q[IdxW-1:0];
        cnt_q    <= cnt_q + CntW'(1);
      end
      if (ev_vld_q && !is_age) begin
        if (key_hit && !match_q) begin
          match_q <= 1'b1;
        end
        if (!ev_valid && !free_q) begin
          free_q <= 1'b1;
        end
      end
      if (age_kill && (rm_q != nct_pkg::RM_MAX)) begin
        rm_q <= rm_q + nct_pkg::RM_W'(1);
      end
      if (cmd_i.commit) begin
        evicted_q <= do_evict;
      end
    end
  end

  // indexes and data captured alongside the flags above
  always_ff @(posedge clk_i) begin
    if (ev_vld_q && !is_age && key_hit && !match_q) begin
      match_idx_q <= ev_idx_q;
      found_mac_q <= rd_mac_q;
    end
    if (ev_vld_q && !is_age && !ev_valid && !free_q) begin
      free_idx_q <= ev_idx_q;
    end
    if (cmd_i.commit) begin
      wslot_q <= widx;
    end
  end

  assign status_o.last_eval = ev_vld_q && (ev_idx_q == LastIdx);
  assign status_o.is_update = (func_q == nct_pkg::FUNC_UPDATE);

  always_comb begin
    result_o = '0;
    case (func_q)
      nct_pkg::FUNC_UPDATE: begin
        result_o.hit     = match_q;
        result_o.slot    = nct_pkg::SLOT_W'(wslot_q);
        result_o.evicted = evicted_q;
      end
      nct_pkg::FUNC_LOOKUP: begin
        if (match_q) begin
          result_o.hit     = 1'b1;
          result_o.mac_out = found_mac_q;
          result_o.slot    = nct_pkg::SLOT_W'(match_idx_q);
        end
      end
      nct_pkg::FUNC_AGE: begin
        result_o.removed_count = rm_q;
      end
      default: begin
        result_o = '0;
      end
    endcase
  end

  `NCT_ASSERT_NXT(a_commit_sets_valid, clk_i, rst_ni, cmd_i.commit, valid_q[$past(widx)], "written entry not valid")
  `NCT_ASSERT_NXT(a_ptr_moves_on_commit, clk_i, rst_ni, !cmd_i.commit, $stable(evict_ptr_q), "evict pointer moved outside a commit")
  `NCT_ASSERT_NXT(a_rm_grows, clk_i, rst_ni, !cmd_i.load, rm_q >= $past(rm_q), "removed count went down within a request")

endmodule

`default_nettype wire

// ===== sv/neighbor_cache_table_unit.sv =====
// top level of the ipv6 neighbor cache table: stream ports, config registers, result stage
// uses nct_pkg, nct_ctrl and nct_dp
`default_nettype none

// IPv6 neighbor cache of ENTRIES slots mapping a 128-bit address to a 48-bit
// mac. each request on the slave stream carries an operation in tuser
// (update, lookup, age tick, or a no-op that returns an all-zero result) and
// gives exactly one result on the master stream. an update refreshes the
// matching entry, else fills the lowest free slot, else overwrites the slot
// under a round-robin pointer; an age tick turns entries stale and removes
// old stale ones. one request is worked on at a time: the table sits in
// memories that are read one entry per cycle; an update adds a commit step
// after its scan and a no-op skips the scan. a result may wait for the
// master side before it enters the result stage, and the next request is
// taken only after that. a finished result waits in its own register while
// the next request is taken. limits are to be written through the config
// port only while no request is in flight; the block does not enforce it.
// valid bits are cleared by reset at once; no clearing pass is needed.

module neighbor_cache_table_unit #(
  parameter int unsigned ENTRIES = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // request stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [207:0] s_axis_tdata,   // addr_high, addr_low, new_mac, now
  input  logic [1:0]   s_axis_tuser,   // func
  // result stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [63:0]  m_axis_tdata,   // hit, mac_out, slot, evicted, removed_count, pad
  // config write port
  input  logic         cfg_we_i,
  input  logic         cfg_idx_i,
  input  logic [31:0]  cfg_wdata_i
);

  nct_pkg::ctrl_cmd_t  cmd;
  nct_pkg::dp_status_t status;
  nct_pkg::result_t    result;

  logic [31:0] reach_lim_q, stale_lim_q;
  logic        out_vld_q;
  logic [63:0] out_data_q;
  logic        out_free;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reach_lim_q <= nct_pkg::REACHABLE_LIMIT_RST;
      stale_lim_q <= nct_pkg::STALE_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        nct_pkg::REG_REACHABLE_LIMIT: reach_lim_q <= cfg_wdata_i;
        nct_pkg::REG_STALE_LIMIT:     stale_lim_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // result stage can take a new result when empty or draining this cycle
  assign out_free = !out_vld_q || m_axis_tready;

  nct_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_func_i  (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .out_free_i (out_free),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  nct_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .in_func_i      (s_axis_tuser),
    .in_addr_high_i (s_axis_tdata[63:0]),
    .in_addr_low_i  (s_axis_tdata[127:64]),
    .in_new_mac_i   (s_axis_tdata[175:128]),
    .in_now_i       (s_axis_tdata[207:176]),
    .reach_lim_i    (reach_lim_q),
    .stale_lim_i    (stale_lim_q),
    .status_o       (status),
    .result_o       (result)
  );

  // output register, separates the master handshake from the scan
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd.emit) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.emit) begin
      out_data_q <= {3'b000, result};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire

// ===== tb/sv/neighbor_cache_table_unit_test.sv =====
// self-checking testbench of the neighbor cache table: directed and random requests,
// a transaction-level predictor of the cache, and a checker on the result stream
// depends on nct_pkg and neighbor_cache_table_unit
`default_nettype none

module neighbor_cache_table_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import nct_pkg::*;

  localparam int ENTRIES        = 32;
  localparam int KEY_POOL       = 64;
  // watchdog limit lies above the slowest request plus the longest stall and the hold-off
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_OFF_LEN   = 400;

  typedef struct packed {
    func_e             func;
    logic [KEY_W-1:0]  addr_high;
    logic [KEY_W-1:0]  addr_low;
    logic [MAC_W-1:0]  new_mac;
    logic [TIME_W-1:0] now;
  } request_t;

  // dut ports
  logic         clk_i = 1'b0;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [207:0] s_axis_tdata;   // addr_high, addr_low, new_mac, now
  logic [1:0]   s_axis_tuser;   // func
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [63:0]  m_axis_tdata;   // hit, mac_out, slot, evicted, removed_count, pad
  logic         cfg_we_i;
  logic         cfg_idx_i;
  logic [31:0]  cfg_wdata_i;

  neighbor_cache_table_unit #(
    .ENTRIES(ENTRIES)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // predictor copy of the cache
  logic              cache_valid  [ENTRIES];
  logic [KEY_W-1:0]  cache_key_hi [ENTRIES];
  logic [KEY_W-1:0]  cache_key_lo [ENTRIES];
  logic [MAC_W-1:0]  cache_mac    [ENTRIES];
  logic [TIME_W-1:0] cache_seen   [ENTRIES];
  logic              cache_stale  [ENTRIES];
  int                next_victim;
  logic [31:0]       limit_reachable;
  logic [31:0]       limit_stale;

  // results still owed by the dut, oldest first
  result_t pending_results[$];

  // address keys reused so that updates refresh and lookups hit
  logic [KEY_W-1:0] pool_hi[KEY_POOL];
  logic [KEY_W-1:0] pool_lo[KEY_POOL];
  logic [TIME_W-1:0] clock_now;

  // knobs for the idle generators, written by the test tasks
  int tx_gap_pct;
  int rx_stall_pct;
  int hold_off_len;

  int mismatch_count;
  int n_sent, n_checked, n_updates, n_evictions, n_lookup_hits, n_age_ticks, n_removed;

  function automatic int find_entry(input logic [KEY_W-1:0] hi, input logic [KEY_W-1:0] lo);
    int i;
    for (i = 0; i < ENTRIES; i++)
      if (cache_valid[i] && cache_key_hi[i] == hi && cache_key_lo[i] == lo) return i;
    return -1;
  endfunction

  // applies one request to the cache copy and returns the result it must produce
  function automatic result_t resolve_neighbor(input request_t r);
    result_t res;
    int idx;
    int i;
    logic [TIME_W-1:0] age;
    res = '0;
    case (r.func)
      FUNC_UPDATE: begin
        n_updates++;
        idx = find_entry(r.addr_high, r.addr_low);
        if (idx >= 0) begin
          res.hit = 1'b1;
        end else begin
          for (i = 0; i < ENTRIES && idx < 0; i++)
            if (!cache_valid[i]) idx = i;
          // table full: round-robin victim
          if (idx < 0) begin
            idx = next_victim;
            next_victim = (next_victim + 1) % ENTRIES;
            res.evicted = 1'b1;
            n_evictions++;
          end
        end
        cache_key_hi[idx] = r.addr_high;
        cache_key_lo[idx] = r.addr_low;
        cache_mac[idx]    = r.new_mac;
        cache_seen[idx]   = r.now;
        cache_stale[idx]  = 1'b0;
        cache_valid[idx]  = 1'b1;
        res.slot = SLOT_W'(idx);
      end
      FUNC_LOOKUP: begin
        idx = find_entry(r.addr_high, r.addr_low);
        if (idx >= 0) begin
          res.hit     = 1'b1;
          res.mac_out = cache_mac[idx];
          res.slot    = SLOT_W'(idx);
          n_lookup_hits++;
        end
      end
      FUNC_AGE: begin
        n_age_ticks++;
        for (i = 0; i < ENTRIES; i++) begin
          if (cache_valid[i]) begin
            age = r.now - cache_seen[i];
            // strictly greater: an age equal to a limit leaves the entry alone
            if (!cache_stale[i] && age > limit_reachable) cache_stale[i] = 1'b1;
            if (cache_stale[i] && age > limit_stale) begin
              cache_valid[i] = 1'b0;
              if (res.removed_count != RM_MAX) res.removed_count++;
              n_removed++;
            end
          end
        end
      end
      default: ;  // no-op gives an all-zero result
    endcase
    return res;
  endfunction

  function automatic int pick_gap(input int pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(4) == 0) return $urandom_range(40, 10);
    return $urandom_range(3, 1);
  endfunction

  // sender: one request, accepted when tvalid and tready meet at a rising edge
  task automatic send_request(input request_t r);
    int gap;
    gap = pick_gap(tx_gap_pct);
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {r.now, r.new_mac, r.addr_low, r.addr_high};
    s_axis_tuser  <= r.func;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(resolve_neighbor(r));
    n_sent++;
  endtask

  task automatic send_op(input func_e f, input logic [KEY_W-1:0] hi, input logic [KEY_W-1:0] lo,
                         input logic [MAC_W-1:0] mac, input logic [TIME_W-1:0] t);
    request_t r;
    r.func      = f;
    r.addr_high = hi;
    r.addr_low  = lo;
    r.new_mac   = mac;
    r.now       = t;
    send_request(r);
  endtask

  // stop offering and let every owed result come back
  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic idx, input logic [31:0] value);
    wait_drained();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    if (idx == REG_REACHABLE_LIMIT) limit_reachable = value;
    else limit_stale = value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_limits(input logic [31:0] reach, input logic [31:0] stale);
    write_limit(REG_REACHABLE_LIMIT, reach);
    write_limit(REG_STALE_LIMIT, stale);
  endtask

  // mostly keys from the pool, a few fresh ones; time creeps forward with rare jumps
  task automatic make_request(input int pool_span, input int step_max, output request_t r);
    int sel;
    int pick;
    sel = $urandom_range(99);
    if (sel < 40) r.func = FUNC_UPDATE;
    else if (sel < 80) r.func = FUNC_LOOKUP;
    else if (sel < 95) r.func = FUNC_AGE;
    else r.func = FUNC_NONE;
    if ($urandom_range(9) == 0) begin
      r.addr_high = {$urandom, $urandom};
      r.addr_low  = {$urandom, $urandom};
    end else begin
      pick = $urandom_range(pool_span - 1);
      r.addr_high = pool_hi[pick];
      r.addr_low  = pool_lo[pick];
    end
    r.new_mac = MAC_W'({$urandom, $urandom});
    clock_now += $urandom_range(step_max);
    if ($urandom_range(49) == 0) r.now = $urandom;
    else r.now = clock_now;
  endtask

  task automatic run_random(input int count, input int pool_span, input int step_max);
    request_t r;
    repeat (count) begin
      make_request(pool_span, step_max, r);
      send_request(r);
    end
  endtask

  // empty table, no-op, key extremes, refresh, keys that match in one half only
  task automatic test_basic_ops();
    send_op(FUNC_LOOKUP, '0, '0, '0, '0);
    send_op(FUNC_NONE, '1, '1, '1, '1);
    send_op(FUNC_UPDATE, '1, '1, '1, '1);
    send_op(FUNC_UPDATE, '0, '0, '0, '0);
    send_op(FUNC_LOOKUP, '1, '1, '0, 32'd3);
    send_op(FUNC_LOOKUP, '0, '0, '1, 32'd4);
    send_op(FUNC_LOOKUP, '1, '0, '0, 32'd5);
    send_op(FUNC_LOOKUP, '0, '1, '0, 32'd6);
    send_op(FUNC_UPDATE, '1, '1, 48'h1234_5678_9abc, 32'd7);
    send_op(FUNC_LOOKUP, '1, '1, '0, 32'd8);
  endtask

  // ages right at and just past each limit, across the timer wrap, and both steps in one tick
  task automatic test_aging_boundaries();
    logic [KEY_W-1:0] k1, k2, k3;
    k1 = {$urandom, $urandom};
    k2 = ~k1;
    k3 = {$urandom, $urandom};
    set_limits(32'd10, 32'd20);
    send_op(FUNC_UPDATE, k1, k3, 48'hA5A5_0000_5A5A, 32'd1000);
    send_op(FUNC_AGE, '0, '0, '0, 32'd1010);
    send_op(FUNC_AGE, '0, '0, '0, 32'd1011);
    send_op(FUNC_AGE, '0, '0, '0, 32'd1020);
    send_op(FUNC_AGE, '0, '0, '0, 32'd1021);
    send_op(FUNC_LOOKUP, k1, k3, '0, 32'd1022);
    send_op(FUNC_UPDATE, k2, k3, 48'h0000_FFFF_0001, 32'hFFFF_FFF8);
    send_op(FUNC_AGE, '0, '0, '0, 32'd5);
    send_op(FUNC_LOOKUP, k2, k3, '0, 32'd6);
    send_op(FUNC_UPDATE, k3, k1, 48'h8000_0000_0001, 32'd100);
    send_op(FUNC_AGE, '0, '0, '0, 32'd200);
    send_op(FUNC_LOOKUP, k3, k1, '0, 32'd201);
  endtask

  // smallest and largest limits: small-large, large-small and both small
  task automatic test_limit_extremes();
    set_limits(32'd1, 32'hFFFF_FFFF);
    run_random(120, 40, 4);
    set_limits(32'hFFFF_FFFF, 32'd1);
    run_random(120, 40, 4);
    set_limits(32'd1, 32'd1);
    run_random(120, 40, 4);
  endtask

  // bulk traffic: a roomy table first, then a pool larger than the table
  task automatic test_random_traffic();
    set_limits(32'd40, 32'd150);
    run_random(450, 24, 6);
    set_limits(32'd200, 32'd300);
    run_random(450, 56, 12);
  endtask

  // result side holds off long enough for the request side to back up
  task automatic test_backpressure();
    wait_drained();
    tx_gap_pct = 0;
    hold_off_len = HOLD_OFF_LEN;
    run_random(40, 48, 4);
    tx_gap_pct = 30;
  endtask

  // back-to-back on both sides
  task automatic test_quiet_stream();
    set_limits(REACHABLE_LIMIT_RST, STALE_LIMIT_RST);
    tx_gap_pct = 0;
    rx_stall_pct = 0;
    run_random(200, 48, 2000);
    tx_gap_pct = 30;
    rx_stall_pct = 30;
  endtask

  // result side ready, with random stalls and the requested hold-off
  initial begin : rx_ready_drive
    int hold_left;
    int stall_left;
    hold_left = 0;
    stall_left = 0;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off_len != 0) begin
        hold_left = hold_off_len;
        hold_off_len = 0;
      end
      if (stall_left == 0 && hold_left == 0) stall_left = pick_gap(rx_stall_pct);
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic compare_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  task automatic check_result(input logic [63:0] raw);
    result_t got, want;
    got = result_t'(raw[60:0]);
    if (pending_results.size() == 0) begin
      $display("%0t: result %h arrived with no request pending", $time, raw);
      mismatch_count++;
      return;
    end
    want = pending_results.pop_front();
    compare_field("hit", 64'(want.hit), 64'(got.hit));
    compare_field("mac_out", 64'(want.mac_out), 64'(got.mac_out));
    compare_field("slot", 64'(want.slot), 64'(got.slot));
    compare_field("evicted", 64'(want.evicted), 64'(got.evicted));
    compare_field("removed_count", 64'(want.removed_count), 64'(got.removed_count));
    compare_field("pad", 64'd0, 64'(raw[63:61]));
    n_checked++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) check_result(m_axis_tdata);
  end

  // watchdog: ends the run if neither stream moves for too long
  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("%0t: no request or result moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin : main_sequence
    int i;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = 1'b0;
    cfg_wdata_i   = '0;
    tx_gap_pct    = 30;
    rx_stall_pct  = 30;
    hold_off_len  = 0;
    mismatch_count = 0;
    n_sent = 0; n_checked = 0; n_updates = 0; n_evictions = 0;
    n_lookup_hits = 0; n_age_ticks = 0; n_removed = 0;

    // cache copy matches the reset state: nothing valid, default limits
    for (i = 0; i < ENTRIES; i++) cache_valid[i] = 1'b0;
    next_victim     = 0;
    limit_reachable = REACHABLE_LIMIT_RST;
    limit_stale     = STALE_LIMIT_RST;

    // pool keys share one half with a neighbor so both halves must be compared
    for (i = 0; i < KEY_POOL; i++) begin
      pool_hi[i] = {$urandom, $urandom};
      pool_lo[i] = {$urandom, $urandom};
      if (i % 3 == 1) pool_hi[i] = pool_hi[i-1];
      if (i % 3 == 2) pool_lo[i] = pool_lo[i-2];
    end
    clock_now = 32'hFFFF_F000;  // random part crosses the timer wrap

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_basic_ops();
    test_aging_boundaries();
    test_limit_extremes();
    test_random_traffic();
    test_backpressure();
    test_quiet_stream();

    wait_drained();
    repeat (ENTRIES + 8) @(posedge clk_i);

    $display("checked %0d of %0d requests: %0d updates (%0d evictions), %0d lookup hits",
             n_checked, n_sent, n_updates, n_evictions, n_lookup_hits);
    $display("%0d age ticks removed %0d entries over limits from 1 to 2^32-1",
             n_age_ticks, n_removed);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+sv
sv/nct_pkg.sv
sv/nct_ctrl.sv
sv/nct_dp.sv
sv/neighbor_cache_table_unit.sv
tb/sv/neighbor_cache_table_unit_test.sv
